FILE: rtl/core/skf_pkg.sv
// Package for the scalar Kalman filter: widths, register indexes, reset values,
// controller state type and the saturating add. No dependencies.
package skf_pkg;

  // Field and datapath widths
  localparam int unsigned SampleW  = 16;
  localparam int unsigned EstW     = 32;
  localparam int unsigned CovW     = 32;
  localparam int unsigned FracW    = 24;          // Q8.24 fraction bits
  localparam int unsigned GainW    = FracW + 1;   // gain lies in [0, 1.0]
  localparam int unsigned DiffW    = EstW + 1;    // sample - estimate, exact
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned CntW     = 5;

  // Serial step counts
  localparam logic [CntW-1:0] DivSteps = CntW'(FracW);   // after the integer bit
  localparam logic [CntW-1:0] MulSteps = CntW'(GainW);   // one multiplier bit each

  localparam logic [GainW-1:0] GainOne = GainW'(1) << FracW;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_PROCESS_NOISE      = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_MEASUREMENT_NOISE  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_INITIAL_COVARIANCE = 2'd2;

  // Register reset values
  localparam logic [CovW-1:0] ProcessNoiseRst      = 32'd16777;
  localparam logic [CovW-1:0] MeasurementNoiseRst  = 32'd9110028;
  localparam logic [CovW-1:0] InitialCovarianceRst = 32'd335544;

  typedef logic signed [SampleW-1:0] sample_t;
  typedef logic signed [EstW-1:0]    est_t;
  typedef logic [CovW-1:0]           cov_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD_Q,
    ST_ADD_R,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_MUL_GO,
    ST_MUL_WAIT,
    ST_WB
  } state_e;

  // Datapath strobes from the controller
  typedef struct packed {
    logic ld_sample;
    logic ld_pp;
    logic ld_den;
    logic div_start;
    logic mul_start;
    logic wb;
  } ctrl_t;

  // Unsigned add that saturates at all ones
  function automatic cov_t sat_add(input cov_t a, input cov_t b);
    logic [CovW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CovW] ? '1 : s[CovW-1:0];
  endfunction

endpackage

FILE: rtl/core/skf_if.sv
// Channel interfaces for the scalar Kalman filter: sample in, estimate out and
// the configuration write channel. Depends on skf_pkg.

interface skf_sample_if;
  import skf_pkg::*;
  logic    valid;
  logic    ready;
  sample_t sample;
  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface skf_estimate_if;
  import skf_pkg::*;
  logic valid;
  logic ready;
  est_t estimate;
  modport source (output valid, output estimate, input ready);
  modport sink   (input valid, input estimate, output ready);
endinterface

interface skf_cfg_if;
  import skf_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/skf_div.sv
// Bit-serial restoring divider for the gain: q = floor(num * 2^24 / den).
// Requires num <= den; a zero denominator gives zero. Depends on skf_pkg.
module skf_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  skf_pkg::cov_t             num_i,
  input  skf_pkg::cov_t             den_i,
  output logic                      done_o,
  output logic [skf_pkg::GainW-1:0] quot_o
);
  import skf_pkg::*;

  logic              busy_q, done_q, zero_q;
  logic [CntW-1:0]   cnt_q;
  cov_t              rem_q, den_q;
  logic [GainW-1:0]  quot_q;

  logic [CovW:0]     rem_dbl, rem_sub;
  logic              step_ge;
  logic              first_ge;

  // One quotient bit per cycle
  always_comb begin
    rem_dbl  = {rem_q, 1'b0};
    rem_sub  = rem_dbl - {1'b0, den_q};
    step_ge  = rem_dbl >= {1'b0, den_q};
    first_ge = num_i >= den_i;
  end

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CntW'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= DivSteps;
      end else if (busy_q) begin
        cnt_q <= cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // Remainder and quotient shift register; integer bit taken at start
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q  <= den_i;
      zero_q <= (den_i == '0);
      rem_q  <= first_ge ? num_i - den_i : num_i;
      quot_q <= {{(GainW-1){1'b0}}, first_ge};
    end else if (busy_q) begin
      rem_q  <= step_ge ? rem_sub[CovW-1:0] : rem_dbl[CovW-1:0];
      quot_q <= {quot_q[GainW-2:0], step_ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = zero_q ? '0 : quot_q;

endmodule

FILE: rtl/core/skf_mul.sv
// Bit-serial shift-add multiplier: signed 33-bit multiplicand times unsigned
// 25-bit multiplier, result floor(product / 2^24) modulo 2^32. Depends on skf_pkg.
module skf_mul (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic signed [skf_pkg::DiffW-1:0] mcand_i,
  input  logic [skf_pkg::GainW-1:0]        mplier_i,
  output logic                             done_o,
  output logic [skf_pkg::EstW-1:0]         res_o
);
  import skf_pkg::*;

  localparam int unsigned AccW = DiffW + 2;

  logic                    busy_q, done_q;
  logic [CntW-1:0]         cnt_q;
  logic signed [DiffW-1:0] mcand_q;
  logic signed [AccW-1:0]  hi_q;
  logic [GainW-1:0]        lo_q;    // multiplier bits out, product bits in
  logic signed [AccW-1:0]  sum;

  // Add the multiplicand when the current multiplier bit is set
  always_comb begin
    sum = hi_q + (lo_q[0] ? AccW'(mcand_q) : AccW'(0));
  end

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CntW'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= MulSteps;
      end else if (busy_q) begin
        cnt_q <= cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // Accumulator shifts right one bit per step
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mcand_q <= mcand_i;
      hi_q    <= '0;
      lo_q    <= mplier_i;
    end else if (busy_q) begin
      hi_q <= {sum[AccW-1], sum[AccW-1:1]};
      lo_q <= {sum[0], lo_q[GainW-1:1]};
    end
  end

  assign done_o = done_q;
  assign res_o  = {hi_q[EstW-2:0], lo_q[GainW-1]};

endmodule

FILE: rtl/core/scalar_kalman_filter.sv
// Scalar Kalman filter top level: controller, state registers, configuration
// registers and output register. Depends on skf_pkg, skf_if, skf_div, skf_mul.
//
// Usage:
//   sample_i   - one signed 16-bit sample per item (valid/ready).
//   estimate_o - one signed Q16.16 estimate per sample (valid/ready).
//   cfg_i      - register writes: 0 process noise, 1 measurement noise,
//                2 initial covariance (also loads the covariance at once).
//                Always ready; write only while no sample is in flight.
// Timing: an accepted sample passes through the two sums, the gain divider
//   (one quotient bit a cycle) and the two serial multipliers, which run side
//   by side, before the write-back shows its estimate. One sample is in flight
//   at a time, so the block takes no new sample until the last update is
//   written back.
// Stall: the estimate is held in the output register until taken; a finished
//   update waits for that register, and no new sample is taken meanwhile.
// Reset: estimate clears to zero, covariance loads the initial covariance
//   reset value, the noise registers take their reset values.
module scalar_kalman_filter (
  input  logic     clk_i,
  input  logic     rst_ni,
  skf_sample_if.sink     sample_i,
  skf_estimate_if.source estimate_o,
  skf_cfg_if.sink        cfg_i
);
  import skf_pkg::*;

  state_e state_q, state_d;
  ctrl_t  ctrl;

  cov_t                    q_noise_q, r_noise_q, p_init_q;
  cov_t                    cov_q, pp_q, den_q;
  est_t                    est_q;
  sample_t                 sample_q;
  logic signed [DiffW-1:0] diff_q;
  logic                    out_valid_q;

  logic                    div_done, mul_est_done, mul_cov_done;
  logic [GainW-1:0]        gain;
  logic [EstW-1:0]         est_step;
  logic [CovW-1:0]         cov_next;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:     if (sample_i.valid) state_d = ST_ADD_Q;
      ST_ADD_Q:    state_d = ST_ADD_R;
      ST_ADD_R:    state_d = ST_DIV_GO;
      ST_DIV_GO:   state_d = ST_DIV_WAIT;
      ST_DIV_WAIT: if (div_done) state_d = ST_MUL_GO;
      ST_MUL_GO:   state_d = ST_MUL_WAIT;
      ST_MUL_WAIT: if (mul_est_done && mul_cov_done) state_d = ST_WB;
      ST_WB:       if (!out_valid_q || estimate_o.ready) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // Controller outputs
  always_comb begin
    ctrl = '0;
    unique case (state_q)
      ST_IDLE:     ctrl.ld_sample = sample_i.valid;
      ST_ADD_Q:    ctrl.ld_pp     = 1'b1;
      ST_ADD_R:    ctrl.ld_den    = 1'b1;
      ST_DIV_GO:   ctrl.div_start = 1'b1;
      ST_DIV_WAIT: ctrl = '0;
      ST_MUL_GO:   ctrl.mul_start = 1'b1;
      ST_MUL_WAIT: ctrl = '0;
      ST_WB:       ctrl.wb        = !out_valid_q || estimate_o.ready;
      default:     ctrl = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Configuration, filter state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_noise_q   <= ProcessNoiseRst;
      r_noise_q   <= MeasurementNoiseRst;
      p_init_q    <= InitialCovarianceRst;
      cov_q       <= InitialCovarianceRst;
      est_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (ctrl.wb) begin
        est_q       <= est_q + est_t'(est_step);
        cov_q       <= cov_next;
        out_valid_q <= 1'b1;
      end else if (estimate_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_i.valid) begin
        unique case (cfg_i.index)
          CFG_PROCESS_NOISE:     q_noise_q <= cfg_i.data;
          CFG_MEASUREMENT_NOISE: r_noise_q <= cfg_i.data;
          CFG_INITIAL_COVARIANCE: begin
            p_init_q <= cfg_i.data;
            cov_q    <= cfg_i.data;
          end
          default: ;
        endcase
      end
    end
  end

  // Working registers for one update
  always_ff @(posedge clk_i) begin
    if (ctrl.ld_sample) begin
      sample_q <= sample_i.sample;
    end
    if (ctrl.ld_pp) begin
      pp_q <= sat_add(cov_q, q_noise_q);
    end
    if (ctrl.ld_den) begin
      den_q  <= sat_add(pp_q, r_noise_q);
      diff_q <= {sample_q[SampleW-1], sample_q, 16'h0000} - DiffW'(est_q);
    end
  end

  // Gain K = Pp / (Pp + R)
  skf_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ctrl.div_start),
    .num_i   (pp_q),
    .den_i   (den_q),
    .done_o  (div_done),
    .quot_o  (gain)
  );

  // Estimate step K * (s - x)
  skf_mul u_mul_est (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (ctrl.mul_start),
    .mcand_i  (diff_q),
    .mplier_i (gain),
    .done_o   (mul_est_done),
    .res_o    (est_step)
  );

  // Covariance (1 - K) * Pp
  skf_mul u_mul_cov (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (ctrl.mul_start),
    .mcand_i  ({1'b0, pp_q}),
    .mplier_i (GainOne - gain),
    .done_o   (mul_cov_done),
    .res_o    (cov_next)
  );

  assign sample_i.ready      = (state_q == ST_IDLE);
  assign cfg_i.ready         = 1'b1;
  assign estimate_o.valid    = out_valid_q;
  assign estimate_o.estimate = est_q;

endmodule

FILE: rtl/core/skf_chk.sv
// Port-level checker for the scalar Kalman filter, bound to the top level.
// Depends on skf_pkg.
module skf_chk (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input skf_pkg::est_t     estimate_i
);
  import skf_pkg::*;

  // A stalled estimate holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(estimate_i))
    else $error("estimate changed while stalled");

  // One sample in flight: no item right after an accepted one
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("sample taken while an update runs");

  // A new result appears only at the end of an update
  a_out_from_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i))
    else $error("estimate shown without an update");

  // Convex blend keeps the estimate within the scaled sample range
  a_est_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !estimate_i[EstW-1] |->
      (estimate_i[EstW-2:16] != 15'h7fff) || (estimate_i[15:0] == 16'h0000))
    else $error("estimate beyond sample range");

endmodule

bind scalar_kalman_filter skf_chk u_skf_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (sample_i.valid),
  .in_ready_i  (sample_i.ready),
  .out_valid_i (estimate_o.valid),
  .out_ready_i (estimate_o.ready),
  .estimate_i  (estimate_o.estimate)
);

FILE: sim/scalar_kalman_filter_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for scalar_kalman_filter: queued sample driver, estimate
// monitor with an in-line fixed-point filter predictor. Depends on skf_pkg and skf_if.

module scalar_kalman_filter_test;
  import skf_pkg::*;

  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned SettleCycles = 60;
  localparam int unsigned PhaseItems = 50;
  localparam int unsigned PhaseCount = 8;
  localparam logic [CfgIdxW-1:0] CfgUnused = 2'd3;
  localparam logic [63:0] OneQ24 = 64'd16777216;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  // Input-side drive registers, known from time zero
  logic                smp_valid = 1'b0;
  sample_t             smp_data  = '0;
  logic                est_ready = 1'b1;
  logic                cfg_valid = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data  = '0;

  skf_sample_if   smp_if ();
  skf_estimate_if est_if ();
  skf_cfg_if      cfg_if ();

  assign smp_if.valid  = smp_valid;
  assign smp_if.sample = smp_data;
  assign est_if.ready  = est_ready;
  assign cfg_if.valid  = cfg_valid;
  assign cfg_if.index  = cfg_index;
  assign cfg_if.data   = cfg_data;

  scalar_kalman_filter u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .sample_i   (smp_if.sink),
    .estimate_o (est_if.source),
    .cfg_i      (cfg_if.sink)
  );

  // Stimulus and expectations
  sample_t sample_fifo[$];
  est_t    estimate_queue[$];

  // Filter model state and registers
  est_t filt_est   = '0;
  cov_t filt_cov   = InitialCovarianceRst;
  cov_t noise_q    = ProcessNoiseRst;
  cov_t noise_r    = MeasurementNoiseRst;
  cov_t cov_init   = InitialCovarianceRst;

  int unsigned err_count   = 0;
  int unsigned taken_count = 0;
  int unsigned cfg_count   = 0;
  int unsigned cycle_count = 0;
  logic        idle_on  = 1'b1;
  logic        hold_req = 1'b0;

  // Clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Saturating Q8.24 sum
  function automatic cov_t cov_sum(input cov_t a, input cov_t b);
    logic [CovW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CovW] ? '1 : s[CovW-1:0];
  endfunction

  // One filter update; advances the model state and returns the new estimate
  function automatic est_t kalman_update(input sample_t s);
    cov_t               pp;
    cov_t               den;
    logic [63:0]        gain;
    logic signed [63:0] diff;
    logic signed [63:0] corr;
    pp   = cov_sum(filt_cov, noise_q);
    den  = cov_sum(pp, noise_r);
    gain = (den == '0) ? 64'd0 : ({32'd0, pp} << FracW) / {32'd0, den};
    diff = ($signed({{48{s[SampleW-1]}}, s}) <<< 16) -
           $signed({{32{filt_est[EstW-1]}}, filt_est});
    // arithmetic shift gives floor toward minus infinity
    corr = ($signed(gain) * diff) >>> FracW;
    filt_est = filt_est + est_t'(corr[EstW-1:0]);
    filt_cov = cov_t'(((OneQ24 - gain) * {32'd0, pp}) >> FracW);
    return filt_est;
  endfunction

  // Noise and covariance values: extremes, near-unity, small and wide
  function automatic cov_t rand_noise();
    cov_t v;
    case ($urandom_range(0, 5))
      0: v = '0;
      1: v = '1;
      2: v = $urandom;
      3: v = $urandom_range(0, 32'h0200_0000);
      4: v = $urandom_range(0, 32'h0010_0000);
      default: v = $urandom & 32'h0FFF_FFFF;
    endcase
    return v;
  endfunction

  // Register write on the config channel; waits for the monitor to see it
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    int unsigned n;
    n = cfg_count;
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(negedge clk_i); while (cfg_count == n);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (sample_fifo.size() != 0 || estimate_queue.size() != 0) @(negedge clk_i);
  endtask

  // Sample driver: offers the queue head, a random gap after some accepted items
  always @(negedge clk_i) begin : sample_driver
    int unsigned seen_count;
    int unsigned gap_left;
    if (taken_count != seen_count) begin
      seen_count = taken_count;
      if (idle_on && $urandom_range(0, 2) == 0) gap_left = $urandom_range(1, 13);
    end
    if (gap_left != 0) begin
      gap_left = gap_left - 1;
      smp_valid <= 1'b0;
    end else if (sample_fifo.size() != 0) begin
      smp_valid <= 1'b1;
      smp_data  <= sample_fifo[0];
    end else begin
      smp_valid <= 1'b0;
    end
  end

  // Estimate receiver: one long hold-off on request, random stall bursts otherwise
  always @(negedge clk_i) begin : estimate_sink
    int unsigned hold_cnt;
    int unsigned stall_left;
    bit          hold_done;
    if (hold_req && !hold_done) begin
      est_ready <= 1'b0;
      hold_cnt = hold_cnt + 1;
      if (hold_cnt >= HoldCycles) hold_done = 1'b1;
    end else if (stall_left != 0) begin
      stall_left = stall_left - 1;
      est_ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(1, 13) - 1;
      est_ready <= 1'b0;
    end else begin
      est_ready <= 1'b1;
    end
  end

  // Monitor: checks estimates, predicts on accepted samples, tracks register writes
  always @(posedge clk_i) begin : monitor
    est_t want;
    if (rst_ni) begin
      if (est_if.valid && est_if.ready) begin
        if (estimate_queue.size() == 0) begin
          err_count = err_count + 1;
          if (err_count <= 20)
            $display("%0t: estimate %0d with none expected", $time, est_if.estimate);
        end else begin
          want = estimate_queue.pop_front();
          if (want !== est_if.estimate) begin
            err_count = err_count + 1;
            if (err_count <= 20)
              $display("%0t: estimate mismatch, expected %0d, actual %0d",
                       $time, want, est_if.estimate);
          end
        end
      end
      if (smp_if.valid && smp_if.ready) begin
        estimate_queue.push_back(kalman_update(smp_if.sample));
        void'(sample_fifo.pop_front());
        taken_count = taken_count + 1;
      end
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.index)
          CFG_PROCESS_NOISE:     noise_q = cfg_if.data;
          CFG_MEASUREMENT_NOISE: noise_r = cfg_if.data;
          CFG_INITIAL_COVARIANCE: begin
            cov_init = cfg_if.data;
            filt_cov = cfg_if.data;
          end
          default: ;
        endcase
        cfg_count = cfg_count + 1;
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count = cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("FAIL scalar_kalman_filter");
      $finish;
    end
  end

  // Test sequence
  initial begin
    int   level;
    int   ph;
    int   i;
    int   pick;
    sample_t s;

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset settings: field extremes and alternating bit patterns
    sample_fifo.push_back(sample_t'(0));
    sample_fifo.push_back(sample_t'(16'h7FFF));
    sample_fifo.push_back(sample_t'(16'h7FFF));
    sample_fifo.push_back(sample_t'(16'h8000));
    sample_fifo.push_back(sample_t'(16'h8000));
    sample_fifo.push_back(sample_t'(16'hFFFF));
    sample_fifo.push_back(sample_t'(16'h0001));
    sample_fifo.push_back(sample_t'(16'h5555));
    sample_fifo.push_back(sample_t'(16'hAAAA));
    wait_drained();

    // All noise zero: zero denominator, estimate held
    write_reg(CFG_PROCESS_NOISE, '0);
    write_reg(CFG_MEASUREMENT_NOISE, '0);
    write_reg(CFG_INITIAL_COVARIANCE, '0);
    sample_fifo.push_back(sample_t'(1000));
    sample_fifo.push_back(sample_t'(-1000));
    sample_fifo.push_back(sample_t'(16'h7FFF));
    wait_drained();

    // Unity gain: estimate jumps straight to the first sample; covariance then drops to zero and later estimates hold
    write_reg(CFG_INITIAL_COVARIANCE, 32'h0100_0000);
    sample_fifo.push_back(sample_t'(16'h8000));
    sample_fifo.push_back(sample_t'(16'h7FFF));
    sample_fifo.push_back(sample_t'(0));
    wait_drained();

    // Everything at full scale: both sums saturate
    write_reg(CFG_PROCESS_NOISE, '1);
    write_reg(CFG_MEASUREMENT_NOISE, '1);
    write_reg(CFG_INITIAL_COVARIANCE, '1);
    sample_fifo.push_back(sample_t'(16'h7FFF));
    sample_fifo.push_back(sample_t'(16'h8000));
    sample_fifo.push_back(sample_t'(12345));
    sample_fifo.push_back(sample_t'(-1));
    wait_drained();

    // Write to the unused index must change nothing
    write_reg(CfgUnused, $urandom);
    write_reg(CFG_MEASUREMENT_NOISE, 32'd1);
    sample_fifo.push_back(sample_t'(-20000));
    sample_fifo.push_back(sample_t'(20000));

    // Random phases, each with its own settings; sender drains between phases
    for (ph = 0; ph < PhaseCount; ph++) begin
      wait_drained();
      if (ph == PhaseCount - 1) begin
        idle_on = 1'b0;
        write_reg(CFG_PROCESS_NOISE, ProcessNoiseRst);
        write_reg(CFG_MEASUREMENT_NOISE, MeasurementNoiseRst);
        write_reg(CFG_INITIAL_COVARIANCE, InitialCovarianceRst);
      end else begin
        if ($urandom_range(0, 1) == 0) write_reg(CfgUnused, $urandom);
        write_reg(CFG_PROCESS_NOISE, rand_noise());
        write_reg(CFG_MEASUREMENT_NOISE, rand_noise());
        write_reg(CFG_INITIAL_COVARIANCE, rand_noise());
      end
      // receiver holds off while the sender keeps offering
      if (ph == 2) hold_req = 1'b1;
      level = int'($urandom_range(0, 65535)) - 32768;
      for (i = 0; i < PhaseItems; i++) begin
        pick = $urandom_range(0, 9);
        if (pick == 0)
          s = ($urandom_range(0, 1) == 0) ? sample_t'(16'h7FFF) : sample_t'(16'h8000);
        else if (pick < 3)
          s = sample_t'($urandom);
        else
          s = sample_t'(level + int'($urandom_range(0, 512)) - 256);
        sample_fifo.push_back(s);
      end
    end

    wait_drained();
    repeat (SettleCycles) @(posedge clk_i);
    if (err_count == 0) begin
      $display("PASS scalar_kalman_filter");
    end else begin
      $display("FAIL scalar_kalman_filter");
    end
    $finish;
  end

endmodule
